@@ design/tcc_pkg.sv @@
// Package for the text console cell engine: command and status codes,
// register indexes, reset values and the configuration struct.
// No dependencies.
`default_nettype none

package tcc_pkg;

    // Default screen geometry limits
    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 64;

    // Command codes
    localparam logic [3:0] CMD_CLEAR  = 4'd0;
    localparam logic [3:0] CMD_PUT    = 4'd1;
    localparam logic [3:0] CMD_CURSOR = 4'd2;
    localparam logic [3:0] CMD_SCROLL = 4'd3;
    localparam logic [3:0] CMD_VIS    = 4'd4;
    localparam logic [3:0] CMD_STYLE  = 4'd5;
    localparam logic [3:0] CMD_INDEX  = 4'd6;
    localparam logic [3:0] CMD_RGB    = 4'd7;
    localparam logic [3:0] CMD_READ   = 4'd8;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    // Style codes
    localparam logic [1:0] STY_EMPH     = 2'd1;
    localparam logic [7:0] EMPHASIS_BIT = 8'h04;

    // Register indexes (word address bits)
    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_NORMAL   = 2'd2;
    localparam logic [1:0] REG_INVERTED = 2'd3;

    // Reset values
    localparam logic [7:0] WIDTH_RST    = 8'd80;
    localparam logic [6:0] HEIGHT_RST   = 7'd25;
    localparam logic [7:0] NORMAL_RST   = 8'h0f;
    localparam logic [7:0] INVERTED_RST = 8'hf0;
    localparam logic [7:0] ATTR_RST     = 8'h0f;

    localparam logic [7:0] BLANK_CHAR = 8'h20;

    typedef struct packed {
        logic [7:0] screen_width;
        logic [6:0] screen_height;
        logic [7:0] norm_attr;
        logic [7:0] inv_attr;
    } t_cfg;

endpackage

`default_nettype wire

@@ design/tcc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module tcc_ram #(
    parameter int P_WIDTH = 16,
    parameter int P_DEPTH = 8192,
    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [AW-1:0]      i_waddr,
    input  wire logic [P_WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]      i_raddr,
    output logic      [P_WIDTH-1:0] o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/tcc_cfg.sv @@
// APB-style configuration registers of the console engine.
// Depends on tcc_pkg.
`default_nettype none

module tcc_cfg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output tcc_pkg::t_cfg    o_cfg
);

    tcc_pkg::t_cfg r_cfg;
    logic          wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width  <= tcc_pkg::WIDTH_RST;
            r_cfg.screen_height <= tcc_pkg::HEIGHT_RST;
            r_cfg.norm_attr     <= tcc_pkg::NORMAL_RST;
            r_cfg.inv_attr      <= tcc_pkg::INVERTED_RST;
        end else if (wr) begin
            unique case (paddr[3:2])
                tcc_pkg::REG_WIDTH:    r_cfg.screen_width  <= pwdata[7:0];
                tcc_pkg::REG_HEIGHT:   r_cfg.screen_height <= pwdata[6:0];
                tcc_pkg::REG_NORMAL:   r_cfg.norm_attr     <= pwdata[7:0];
                tcc_pkg::REG_INVERTED: r_cfg.inv_attr      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (paddr[3:2])
            tcc_pkg::REG_WIDTH:    prdata = {24'd0, r_cfg.screen_width};
            tcc_pkg::REG_HEIGHT:   prdata = {25'd0, r_cfg.screen_height};
            tcc_pkg::REG_NORMAL:   prdata = {24'd0, r_cfg.norm_attr};
            tcc_pkg::REG_INVERTED: prdata = {24'd0, r_cfg.inv_attr};
            default:               prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ design/tcc_sweep.sv @@
// Sweep sequencer for clear and scroll: walks every cell once, copying a
// cell from shift entries away or writing the blank fill word.
// Drives the RAM ports of tcc_ram through the top level; no package use.
`default_nettype none

module tcc_sweep #(
    parameter int P_CELLS = 8192,
    localparam int AW = (P_CELLS > 1) ? $clog2(P_CELLS) : 1,
    localparam int CW = $clog2(P_CELLS + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [CW-1:0] i_total,
    input  wire logic [CW-1:0] i_shift,
    input  wire logic          i_down,
    input  wire logic [15:0]   i_fill,
    input  wire logic [15:0]   i_rdata,
    output logic      [AW-1:0] o_raddr,
    output logic               o_we,
    output logic      [AW-1:0] o_waddr,
    output logic      [15:0]   o_wdata,
    output logic               o_busy
);

    logic          r_active;
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_total;
    logic [CW-1:0] r_shift;
    logic [CW-1:0] r_copy;
    logic          r_down;
    logic [15:0]   r_fill;
    logic          r_wv;
    logic [AW-1:0] r_waddr;
    logic          r_wfill;

    logic [CW-1:0] dst;
    logic [CW-1:0] src;
    logic          is_copy;

    // address generation: upward walks from the top, downward from the end
    always_comb begin
        if (r_down) begin
            dst = r_total - CW'(1) - r_k;
            src = dst - r_shift;
        end else begin
            dst = r_k;
            src = r_k + r_shift;
        end
        is_copy = (r_k < r_copy);
    end

    // control and write stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_wv     <= 1'b0;
        end else begin
            if (i_start) begin
                r_active <= 1'b1;
            end else if (r_active && (r_k == r_total - CW'(1))) begin
                r_active <= 1'b0;
            end
            r_wv <= r_active;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_k     <= '0;
            r_total <= i_total;
            r_shift <= i_shift;
            r_copy  <= i_total - i_shift;
            r_down  <= i_down;
            r_fill  <= i_fill;
        end else if (r_active) begin
            r_k <= r_k + CW'(1);
        end
        r_waddr <= dst[AW-1:0];
        r_wfill <= !is_copy;
    end

    assign o_raddr = src[AW-1:0];
    assign o_we    = r_wv;
    assign o_waddr = r_waddr;
    assign o_wdata = r_wfill ? r_fill : i_rdata;
    assign o_busy  = r_active || r_wv;

endmodule

`default_nettype wire

@@ design/text_console_cell_engine.sv @@
// Text console cell engine: command sequencer, cursor and attribute state.
// Depends on tcc_pkg, tcc_ram, tcc_cfg and tcc_sweep.
//
// One command word in gives one result word out. Attribute, visibility,
// cursor set and putchar are accepted, then executed against the cell
// memory; read cell also waits for the registered memory read. Clear and
// a nonzero scroll run a sweep that moves one cell per cycle through the
// single write port of the cell memory. A result waiting in the output
// register does not hold back the next command; only a second finished
// result waits for it. Cell contents are undefined after reset until a
// clear, putchar or scroll has written them.
`default_nettype none

module text_console_cell_engine #(
    parameter int MAX_COLS = tcc_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = tcc_pkg::MAX_ROWS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // command word
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [3:0]        i_command,
    input  wire logic [7:0]        i_character,
    input  wire logic [7:0]        i_row,
    input  wire logic [7:0]        i_col,
    input  wire logic signed [7:0] i_scroll_amount,
    input  wire logic              i_visible,
    input  wire logic [1:0]        i_style_code,
    input  wire logic [3:0]        i_fg_index,
    input  wire logic [3:0]        i_bg_index,
    input  wire logic              i_bright,
    input  wire logic [23:0]       i_fg_rgb,
    input  wire logic [23:0]       i_bg_rgb,
    // result word
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic      [1:0]        o_status,
    output logic      [7:0]        o_cell_char,
    output logic      [7:0]        o_cell_attr,
    output logic      [15:0]       o_cursor_offset,
    output logic                   o_cursor_hidden,
    output logic      [7:0]        o_current_attr,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    localparam int NUM_CELLS = MAX_COLS * MAX_ROWS;
    localparam int AW  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int CW  = $clog2(NUM_CELLS + 1);
    localparam int WW  = $clog2(MAX_COLS + 1);
    localparam int HW  = $clog2(MAX_ROWS + 1);
    localparam int BW  = (HW > 8) ? HW : 8;
    localparam int PW  = WW + BW + 1;
    localparam int KW  = ((WW > BW) ? WW : BW) + 2;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_RDWT  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    tcc_pkg::t_cfg cfg;

    logic [2:0]    r_state, n_state;
    logic [7:0]    r_attr, n_attr;
    logic [15:0]   r_cursor, n_cursor;
    logic          r_hidden, n_hidden;
    logic [1:0]    r_st, n_st;
    logic [7:0]    r_cc, n_cc;
    logic [7:0]    r_ca, n_ca;
    logic          r_ov;

    logic [3:0]    r_cmd;
    logic [7:0]    r_char;
    logic [7:0]    r_mag;
    logic          r_down;
    logic          r_vis;
    logic [1:0]    r_sty;
    logic [3:0]    r_fgi;
    logic [3:0]    r_bgi;
    logic          r_brt;
    logic [23:0]   r_fgr;
    logic [23:0]   r_bgr;
    logic          r_in_range;
    logic [PW-1:0] r_prod;
    logic [CW-1:0] r_total, n_total;

    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic          accept;
    logic          sweep_cmd;
    logic [BW-1:0] mul_b;
    logic [7:0]    mul_add;
    logic [PW-1:0] prod;
    logic [31:0]   prod32;
    logic [31:0]   prod_inc;

    logic          fin;
    logic          can_load;
    logic          load;

    logic          top_we;
    logic          sw_start;
    logic [CW-1:0] sw_total;
    logic [CW-1:0] sw_shift;
    logic          sw_busy;
    logic [AW-1:0] sw_raddr;
    logic          sw_we;
    logic [AW-1:0] sw_waddr;
    logic [15:0]   sw_wdata;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    tcc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // effective geometry, clamped to 1..MAX
    always_comb begin
        if (cfg.screen_width == 8'd0) begin
            eff_w = WW'(1);
        end else if (KW'(cfg.screen_width) > KW'(MAX_COLS)) begin
            eff_w = WW'(MAX_COLS);
        end else begin
            eff_w = WW'(cfg.screen_width);
        end
        if (cfg.screen_height == 7'd0) begin
            eff_h = HW'(1);
        end else if (KW'(cfg.screen_height) > KW'(MAX_ROWS)) begin
            eff_h = HW'(MAX_ROWS);
        end else begin
            eff_h = HW'(cfg.screen_height);
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign sweep_cmd  = (i_command == tcc_pkg::CMD_CLEAR) ||
                        (i_command == tcc_pkg::CMD_SCROLL);

    // shared multiplier: cell index or cell count at accept, shift length for scroll
    always_comb begin
        if (r_state == S_SHIFT) begin
            mul_b   = BW'(r_mag);
            mul_add = 8'd0;
        end else if (sweep_cmd) begin
            mul_b   = BW'(eff_h);
            mul_add = 8'd0;
        end else begin
            mul_b   = BW'(i_row);
            mul_add = i_col;
        end
        prod = PW'(eff_w) * PW'(mul_b) + PW'(mul_add);
    end

    assign prod32   = 32'(r_prod);
    assign prod_inc = prod32 + 32'd1;
    assign can_load = !r_ov || i_out_ready;

    // command sequencer
    always_comb begin
        n_state  = r_state;
        n_attr   = r_attr;
        n_cursor = r_cursor;
        n_hidden = r_hidden;
        n_st     = r_st;
        n_cc     = r_cc;
        n_ca     = r_ca;
        n_total  = r_total;
        fin      = 1'b0;
        top_we   = 1'b0;
        sw_start = 1'b0;
        sw_total = r_prod[CW-1:0];
        sw_shift = r_prod[CW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_st = tcc_pkg::ST_OK;
                n_cc = 8'd0;
                n_ca = 8'd0;
                unique case (r_cmd)
                    tcc_pkg::CMD_CLEAR: begin
                        sw_start = 1'b1;
                        n_state  = S_SWEEP;
                    end
                    tcc_pkg::CMD_PUT: begin
                        fin = 1'b1;
                        if (!r_in_range) begin
                            n_st = tcc_pkg::ST_INVALID;
                        end else begin
                            top_we   = 1'b1;
                            n_cursor = prod_inc[15:0];
                        end
                    end
                    tcc_pkg::CMD_CURSOR: begin
                        fin = 1'b1;
                        if (!r_in_range) begin
                            n_st = tcc_pkg::ST_INVALID;
                        end else begin
                            n_cursor = prod32[15:0];
                        end
                    end
                    tcc_pkg::CMD_SCROLL: begin
                        n_total = r_prod[CW-1:0];
                        if (KW'(r_mag) > KW'(eff_h)) begin
                            n_st = tcc_pkg::ST_INVALID;
                            fin  = 1'b1;
                        end else if (r_mag == 8'd0) begin
                            fin = 1'b1;
                        end else begin
                            n_state = S_SHIFT;
                        end
                    end
                    tcc_pkg::CMD_VIS: begin
                        fin      = 1'b1;
                        n_hidden = !r_vis;
                    end
                    tcc_pkg::CMD_STYLE: begin
                        fin = 1'b1;
                        if (r_sty == tcc_pkg::STY_EMPH) begin
                            n_attr = cfg.inv_attr | tcc_pkg::EMPHASIS_BIT;
                        end else begin
                            n_attr = cfg.inv_attr;
                        end
                    end
                    tcc_pkg::CMD_INDEX: begin
                        fin    = 1'b1;
                        n_attr = {1'b0, r_bgi[2:0], r_brt, r_fgi[2:0]};
                    end
                    tcc_pkg::CMD_RGB: begin
                        fin    = 1'b1;
                        n_attr = (r_fgr > r_bgr) ? cfg.norm_attr : cfg.inv_attr;
                    end
                    tcc_pkg::CMD_READ: begin
                        if (!r_in_range) begin
                            n_st = tcc_pkg::ST_INVALID;
                            fin  = 1'b1;
                        end else begin
                            n_state = S_RDWT;
                        end
                    end
                    default: begin
                        fin  = 1'b1;
                        n_st = tcc_pkg::ST_UNKNOWN;
                    end
                endcase
            end
            S_SHIFT: begin
                sw_start = 1'b1;
                sw_total = r_total;
                sw_shift = prod[CW-1:0];
                n_state  = S_SWEEP;
            end
            S_SWEEP: begin
                if (!sw_busy) begin
                    fin = 1'b1;
                end
            end
            S_RDWT: begin
                fin  = 1'b1;
                n_cc = ram_rdata[7:0];
                n_ca = ram_rdata[15:8];
            end
            S_DONE: begin
                if (can_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (fin) begin
            n_state = can_load ? S_IDLE : S_DONE;
        end
    end

    assign load = (fin || (r_state == S_DONE)) && can_load;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_attr   <= tcc_pkg::ATTR_RST;
            r_cursor <= 16'd0;
            r_hidden <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_attr   <= n_attr;
            r_cursor <= n_cursor;
            r_hidden <= n_hidden;
            if (load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // command word capture and pending result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= i_command;
            r_char     <= i_character;
            r_mag      <= i_scroll_amount[7] ? 8'(-i_scroll_amount) : 8'(i_scroll_amount);
            r_down     <= i_scroll_amount[7];
            r_vis      <= i_visible;
            r_sty      <= i_style_code;
            r_fgi      <= i_fg_index;
            r_bgi      <= i_bg_index;
            r_brt      <= i_bright;
            r_fgr      <= i_fg_rgb;
            r_bgr      <= i_bg_rgb;
            r_in_range <= (KW'(i_row) < KW'(eff_h)) && (KW'(i_col) < KW'(eff_w));
            r_prod     <= prod;
        end
        r_total <= n_total;
        r_st    <= n_st;
        r_cc    <= n_cc;
        r_ca    <= n_ca;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            o_status        <= n_st;
            o_cell_char     <= n_cc;
            o_cell_attr     <= n_ca;
            o_cursor_offset <= n_cursor;
            o_cursor_hidden <= n_hidden;
            o_current_attr  <= n_attr;
        end
    end

    assign o_out_valid = r_ov;

    tcc_sweep #(
        .P_CELLS (NUM_CELLS)
    ) u_sweep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sw_start),
        .i_total (sw_total),
        .i_shift (sw_shift),
        .i_down  (r_down && (r_cmd == tcc_pkg::CMD_SCROLL)),
        .i_fill  ({r_attr, tcc_pkg::BLANK_CHAR}),
        .i_rdata (ram_rdata),
        .o_raddr (sw_raddr),
        .o_we    (sw_we),
        .o_waddr (sw_waddr),
        .o_wdata (sw_wdata),
        .o_busy  (sw_busy)
    );

    // cell memory port select: the sweep owns the ports while it runs
    assign ram_we    = sw_busy ? sw_we : top_we;
    assign ram_waddr = sw_busy ? sw_waddr : r_prod[AW-1:0];
    assign ram_wdata = sw_busy ? sw_wdata : {r_attr, r_char};
    assign ram_raddr = sw_busy ? sw_raddr : r_prod[AW-1:0];

    tcc_ram #(
        .P_WIDTH (16),
        .P_DEPTH (NUM_CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // no sweep left running once the sequencer is back to idle
    a_idle_no_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !sw_busy)
        else $error("sweep still busy in idle");

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_out_ready) |-> !load)
        else $error("result overwritten while stalled");

    // single-cell writes never collide with a sweep
    a_port_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(top_we && sw_busy))
        else $error("cell write during sweep");

    // cursor only moves when a command executes
    a_cursor_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_EXEC) |=> $stable(r_cursor))
        else $error("cursor changed outside execute");

endmodule

`default_nettype wire
